// ===== rtl/prqs_pkg.sv =====
// Shared types, codes and defaults for the priority ready-queue scheduler.
package prqs_pkg;

   localparam int DEF_LEVELS  = 8;
   localparam int DEF_THREADS = 64;

   localparam int KIND_W  = 3;
   localparam int ID_W    = 6;
   localparam int LEVEL_W = 8;
   localparam int TOP_W   = 3;

   localparam logic [KIND_W-1:0] KIND_CREATE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MAKE_READY = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SCHEDULE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BLOCK      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXIT       = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    thread;
      logic [LEVEL_W-1:0] level;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  running_id;
      logic             running_valid;
      logic             switched;
      logic [TOP_W-1:0] top_level;
      logic             any_ready;
      logic             fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LEVEL_WAIT,
      ST_APPEND_RD,
      ST_APPEND_WR,
      ST_POP_RD,
      ST_POP_CHK,
      ST_POP_LINK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      APP_SRC_REQ,
      APP_SRC_LEVEL,
      APP_SRC_RUN
   } app_src_type;

   typedef struct packed {
      logic        capture;
      logic        lvl_wr;
      logic        lvl_rd;
      logic        app_load;
      app_src_type app_src;
      logic        tail_rd;
      logic        app_empty_wr;
      logic        app_link_wr;
      logic        pop_rd;
      logic        pop_commit;
      logic        link_rd;
      logic        head_link_wr;
      logic        stop_run;
      logic        set_fault;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              thread_ok;
      logic              app_ready;
      logic              no_work;
      logic              replace;
      logic              running;
      logic              head_eq_tail;
      logic              out_free;
   } status_type;

endpackage

// ===== rtl/prqs_ctrl.sv =====
// Sequencer that steps each request through its queue reads and writes.
module prqs_ctrl import prqs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (status.kind == KIND_CREATE) begin
               state_in = status.thread_ok ? ST_APPEND_RD : ST_FINISH;
            end else if (status.kind == KIND_MAKE_READY) begin
               state_in = status.thread_ok ? ST_LEVEL_WAIT : ST_FINISH;
            end else if (status.kind == KIND_SCHEDULE) begin
               if (status.no_work || !status.replace) state_in = ST_FINISH;
               else if (status.running) state_in = ST_APPEND_RD;
               else state_in = ST_POP_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LEVEL_WAIT: state_in = ST_APPEND_RD;
         ST_APPEND_RD: begin
            if (status.app_ready) state_in = ST_APPEND_WR;
            else if (status.kind == KIND_SCHEDULE) state_in = ST_POP_RD;
            else state_in = ST_FINISH;
         end
         ST_APPEND_WR: begin
            state_in = (status.kind == KIND_SCHEDULE) ? ST_POP_RD : ST_FINISH;
         end
         ST_POP_RD:  state_in = ST_POP_CHK;
         ST_POP_CHK: state_in = status.head_eq_tail ? ST_FINISH : ST_POP_LINK;
         ST_POP_LINK: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.app_src = APP_SRC_REQ;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            priority if (status.kind == KIND_CREATE) begin
               cmd.lvl_wr   = status.thread_ok;
               cmd.app_load = status.thread_ok;
               cmd.app_src  = APP_SRC_REQ;
            end else if (status.kind == KIND_MAKE_READY) begin
               cmd.lvl_rd = status.thread_ok;
            end else if (status.kind == KIND_SCHEDULE) begin
               cmd.set_fault = status.no_work;
               cmd.app_load  = !status.no_work && status.replace && status.running;
               cmd.app_src   = APP_SRC_RUN;
            end else if (status.kind == KIND_BLOCK || status.kind == KIND_EXIT) begin
               cmd.stop_run = 1'b1;
            end else begin
               cmd.stop_run = 1'b0;
            end
         end
         ST_LEVEL_WAIT: begin
            cmd.app_load = 1'b1;
            cmd.app_src  = APP_SRC_LEVEL;
         end
         ST_APPEND_RD: begin
            cmd.tail_rd      = status.app_ready;
            cmd.app_empty_wr = !status.app_ready;
         end
         ST_APPEND_WR: cmd.app_link_wr = 1'b1;
         ST_POP_RD:    cmd.pop_rd = 1'b1;
         ST_POP_CHK: begin
            cmd.pop_commit = 1'b1;
            cmd.link_rd    = !status.head_eq_tail;
         end
         ST_POP_LINK: cmd.head_link_wr = 1'b1;
         ST_FINISH:   cmd.rsp_load = status.out_free;
         default:     req_stall = 1'b1;
      endcase
   end

endmodule

// ===== rtl/prqs_dp.sv =====
// Queue storage, ready bitmap, running-thread registers and result register.
module prqs_dp import prqs_pkg::*; #(
   parameter int LEVELS  = DEF_LEVELS,
   parameter int THREADS = DEF_THREADS
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       rsp_stall,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data,
   output logic       rsp_valid
);

   localparam int LW = $clog2(LEVELS);
   localparam int TW = $clog2(THREADS);

   logic [LW-1:0] thread_level_mem [THREADS];
   logic [TW-1:0] next_link_mem    [THREADS];
   logic [TW-1:0] level_head_mem   [LEVELS];
   logic [TW-1:0] level_tail_mem   [LEVELS];

   req_type       req_ff;
   logic [LW-1:0] top_ff;
   logic [TW-1:0] app_t_ff;
   logic [LW-1:0] app_lv_ff;
   logic [LW-1:0] lvl_rd_ff;
   logic [TW-1:0] head_rd_ff;
   logic [TW-1:0] tail_rd_ff;
   logic [TW-1:0] link_rd_ff;
   logic          switched_ff;
   logic          fault_ff;
   rsp_type       rsp_ff;

   logic [LEVELS-1:0] ready_ff, ready_in;
   logic [TW-1:0]     run_thread_ff, run_thread_in;
   logic [LW-1:0]     run_level_ff, run_level_in;
   logic              run_flag_ff, run_flag_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0] t_idx;
   logic [LW-1:0] sat_lv;
   logic [LW-1:0] top_lv;
   logic          any_ready;
   logic          head_eq_tail;
   logic [TW-1:0] app_t_sel;
   logic [LW-1:0] app_lv_sel;
   logic [LW-1:0] tail_ra;
   rsp_type       rsp_next;

   assign t_idx        = TW'(req_ff.thread);
   assign sat_lv       = (32'(req_ff.level) >= LEVELS) ? LW'(LEVELS - 1) : LW'(req_ff.level);
   assign head_eq_tail = (head_rd_ff == tail_rd_ff);
   assign tail_ra      = cmd.pop_rd ? top_ff : app_lv_ff;

   // highest set bit of the ready bitmap
   always_comb begin
      top_lv    = '0;
      any_ready = |ready_ff;
      for (int i = 0; i < LEVELS; i++) begin
         if (ready_ff[i]) top_lv = LW'(i);
      end
   end

   always_comb begin
      unique case (cmd.app_src)
         APP_SRC_REQ: begin
            app_t_sel  = t_idx;
            app_lv_sel = sat_lv;
         end
         APP_SRC_LEVEL: begin
            app_t_sel  = t_idx;
            app_lv_sel = lvl_rd_ff;
         end
         APP_SRC_RUN: begin
            app_t_sel  = run_thread_ff;
            app_lv_sel = run_level_ff;
         end
         default: begin
            app_t_sel  = t_idx;
            app_lv_sel = sat_lv;
         end
      endcase
   end

   always_comb begin
      ready_in = ready_ff;
      if (cmd.app_empty_wr || cmd.app_link_wr) ready_in[app_lv_ff] = 1'b1;
      if (cmd.pop_commit && head_eq_tail) ready_in[top_ff] = 1'b0;
   end

   always_comb begin
      run_thread_in = run_thread_ff;
      run_level_in  = run_level_ff;
      run_flag_in   = run_flag_ff;
      if (cmd.stop_run) run_flag_in = 1'b0;
      if (cmd.pop_commit) begin
         run_thread_in = head_rd_ff;
         run_level_in  = top_ff;
         run_flag_in   = 1'b1;
      end
   end

   always_comb begin
      rsp_next.running_id    = run_flag_ff ? ID_W'(run_thread_ff) : '0;
      rsp_next.running_valid = run_flag_ff;
      rsp_next.switched      = switched_ff;
      rsp_next.top_level     = any_ready ? TOP_W'(top_lv) : '0;
      rsp_next.any_ready     = any_ready;
      rsp_next.fault         = fault_ff;
   end

   // hold the result while the consumer stalls
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff      <= '0;
         run_thread_ff <= '0;
         run_level_ff  <= '0;
         run_flag_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ready_ff      <= ready_in;
         run_thread_ff <= run_thread_in;
         run_level_ff  <= run_level_in;
         run_flag_ff   <= run_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         top_ff      <= top_lv;
         switched_ff <= 1'b0;
         fault_ff    <= 1'b0;
      end
      if (cmd.set_fault) fault_ff <= 1'b1;
      if (cmd.pop_commit) switched_ff <= !run_flag_ff || (run_thread_ff != head_rd_ff);
      if (cmd.app_load) begin
         app_t_ff  <= app_t_sel;
         app_lv_ff <= app_lv_sel;
      end
      if (cmd.rsp_load) rsp_ff <= rsp_next;
   end

   always_ff @(posedge clock) begin
      if (cmd.lvl_wr) thread_level_mem[t_idx] <= sat_lv;
      if (cmd.lvl_rd) lvl_rd_ff <= thread_level_mem[t_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.app_link_wr) next_link_mem[tail_rd_ff] <= app_t_ff;
      if (cmd.link_rd) link_rd_ff <= next_link_mem[head_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.app_empty_wr) level_head_mem[app_lv_ff] <= app_t_ff;
      else if (cmd.head_link_wr) level_head_mem[top_ff] <= link_rd_ff;
      if (cmd.pop_rd) head_rd_ff <= level_head_mem[top_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.app_empty_wr || cmd.app_link_wr) level_tail_mem[app_lv_ff] <= app_t_ff;
      if (cmd.tail_rd || cmd.pop_rd) tail_rd_ff <= level_tail_mem[tail_ra];
   end

   always_comb begin
      status.kind         = req_ff.kind;
      status.thread_ok    = (32'(req_ff.thread) < THREADS);
      status.app_ready    = ready_ff[app_lv_ff];
      status.no_work      = !run_flag_ff && !any_ready;
      status.replace      = !run_flag_ff || (any_ready && (top_lv >= run_level_ff));
      status.running      = run_flag_ff;
      status.head_eq_tail = head_eq_tail;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/priority_ready_queue_scheduler.sv =====
// Priority ready-queue thread scheduler: sequencer plus queue datapath.
// Block, exit, unknown kinds and schedules that fault or keep the thread go from dispatch
// straight to finish; create and make ready append the thread, and a pop dequeues the head.
// A new transaction is taken only once the last one is through and its result is loaded, as
// the sequencer steps through single-port accesses of the head, tail and link memories.
// Reset clears the sequencer, ready bitmap, running thread and result valid; memories are not.
module priority_ready_queue_scheduler import prqs_pkg::*; #(
   parameter int LEVELS  = DEF_LEVELS,
   parameter int THREADS = DEF_THREADS
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    req_valid,
   output logic    req_stall,
   output rsp_type rsp_data,
   output logic    rsp_valid,
   input  logic    rsp_stall
);

   cmd_type    cmd;
   status_type status;

   prqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prqs_dp #(
      .LEVELS  (LEVELS),
      .THREADS (THREADS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

`ifndef SYNTHESIS
   a_fault_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> !rsp_data.running_valid && !rsp_data.any_ready)
      else $error("fault reported while a thread is runnable");

   a_switch_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switched |-> rsp_data.running_valid && !rsp_data.fault)
      else $error("switch reported without a running thread");

   a_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_ready |-> rsp_data.top_level == '0)
      else $error("top level nonzero with no ready queue");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new transaction accepted while one is in progress");
`endif

endmodule
